// File: sv/rdc_pkg.sv
// Package for the radix digit converter.
// Holds widths, beat and divider structs, base clamping and glyph lookup.
// No dependencies.
package rdc_pkg;

	// Width of the value datapath
	localparam int VALUE_WIDTH = 32;
	localparam int VALUE_IN_W  = 32;
	localparam int BASE_W      = 6;
	localparam int CNT_W       = $clog2(VALUE_WIDTH);

	localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(36);
	localparam logic [BASE_W-1:0] DEC_DIGITS = BASE_W'(10);

	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_LETTER = 8'h37;

	// Input beat
	typedef struct packed {
		logic [VALUE_IN_W-1:0] value;
		logic [BASE_W-1:0]     base;
	} item_t;

	// Result beat
	typedef struct packed {
		logic [7:0]        digit_char;
		logic [BASE_W-1:0] digit_value;
		logic              last_digit;
	} digit_t;

	// Request into the shared divider
	typedef struct packed {
		logic                   go;
		logic [VALUE_WIDTH-1:0] dividend;
		logic [BASE_W-1:0]      divisor;
	} div_req_t;

	// Response from the shared divider
	typedef struct packed {
		logic                   done;
		logic [VALUE_WIDTH-1:0] quotient;
		logic [BASE_W-1:0]      remainder;
	} div_rsp_t;

	// Force the base into 2..36
	function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] raw);
		logic [BASE_W-1:0] b;
		b = raw;
		if (raw < BASE_MIN) begin
			b = BASE_MIN;
		end else if (raw > BASE_MAX) begin
			b = BASE_MAX;
		end
		return b;
	endfunction

	// Map a digit value to '0'-'9' then 'A'-'Z'
	function automatic logic [7:0] digit_glyph(input logic [BASE_W-1:0] dv);
		logic [7:0] c;
		if (dv < DEC_DIGITS) begin
			c = CHAR_ZERO + 8'(dv);
		end else begin
			c = CHAR_LETTER + 8'(dv);
		end
		return c;
	endfunction

endpackage

// File: sv/rdc_divider.sv
// Restoring divider, one quotient bit per cycle.
// Divides a VALUE_WIDTH-bit dividend by a small divisor; depends on rdc_pkg.
module rdc_divider (
	input  logic             clk,
	input  logic             arst_n,
	input  rdc_pkg::div_req_t req,
	output rdc_pkg::div_rsp_t rsp
);
	import rdc_pkg::*;

	logic                   run_q;
	logic                   done_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] quo_q;
	logic [BASE_W-1:0]      rem_q;
	logic [BASE_W-1:0]      dsr_q;

	logic [BASE_W:0]        trial;
	logic [BASE_W:0]        diff;
	logic                   fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = trial >= {1'b0, dsr_q};

	// Control: bit counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (run_q) begin
				if (cnt_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end else if (req.go) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(VALUE_WIDTH - 1);
			end
		end
	end

	// Datapath: partial remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (run_q) begin
			quo_q <= {quo_q[VALUE_WIDTH-2:0], fits};
			rem_q <= fits ? diff[BASE_W-1:0] : trial[BASE_W-1:0];
		end else if (req.go) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// File: sv/radix_digit_converter.sv
// Top level of the radix digit converter: digit sequencer around one shared divider.
// Depends on rdc_pkg and rdc_divider.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  item     | start && !busy        | value[31:0], base[5:0]
//  result   | result_valid (1 cyc)  | digit_char[7:0], digit_value[5:0], last_digit
//
// Each digit takes one full division of the shared restoring divider; busy stays
// high until the item's last digit has been produced.
// Digits leave least significant first; the last one strobes in the cycle busy drops,
// so the next item may start right then. Reset clears the sequencer; the receiver
// cannot stall results.
module radix_digit_converter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rdc_pkg::item_t  item,
	output logic           result_valid,
	output rdc_pkg::digit_t result
);
	import rdc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DIVIDE
	} state_t;

	state_t            state_q;
	logic [BASE_W-1:0] base_q;
	logic              result_valid_q;
	digit_t            result_q;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     more;

	// Another digit follows while the quotient is nonzero
	assign more = div_rsp.quotient != '0;

	// Launch a division on a new item or on the previous quotient
	always_comb begin
		div_req.go       = 1'b0;
		div_req.dividend = div_rsp.quotient;
		div_req.divisor  = base_q;
		unique case (state_q)
			ST_IDLE: begin
				div_req.go       = start;
				div_req.dividend = VALUE_WIDTH'(item.value);
				div_req.divisor  = clamp_base(item.base);
			end
			ST_DIVIDE: begin
				div_req.go = div_rsp.done && more;
			end
			default: begin
				div_req.go = 1'b0;
			end
		endcase
	end

	rdc_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Sequencer and registered result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			base_q         <= BASE_MIN;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						base_q  <= clamp_base(item.base);
						state_q <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					if (div_rsp.done) begin
						result_valid_q       <= 1'b1;
						result_q.digit_value <= div_rsp.remainder;
						result_q.digit_char  <= digit_glyph(div_rsp.remainder);
						result_q.last_digit  <= !more;
						if (!more) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = state_q != ST_IDLE;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sv/rdc_checker.sv
// Port-level checker for the radix digit converter, bound to the top level.
// Depends on rdc_pkg and radix_digit_converter.
module rdc_port_checks (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           result_valid,
	input rdc_pkg::digit_t result
);
	import rdc_pkg::*;

	// An accepted item holds the block busy
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	// A digit that is not last leaves the item still running
	a_more_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last_digit) |-> busy)
		else $error("busy dropped before the last digit");

	// Busy drops exactly with the last digit beat
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (result_valid && result.last_digit))
		else $error("item ended without a last digit");

	// Digit beats are never back to back
	a_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("back to back digit beats");

	// Character matches digit value
	a_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			((result.digit_value < 6'd10) &&
			 (result.digit_char == 8'h30 + {2'b00, result.digit_value})) ||
			((result.digit_value >= 6'd10) && (result.digit_value <= 6'd35) &&
			 (result.digit_char == 8'h37 + {2'b00, result.digit_value})))
		else $error("digit character does not match its value");

endmodule

bind radix_digit_converter rdc_port_checks u_rdc_port_checks (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.result       (result)
);
